// ===== rtl/core/hsfc_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_pkg
// Shared types and constants for the half/single float converter.
// ----------------------------------------------------------------------------
package hsfc_pkg;

  typedef enum logic {
    ACT_WIDEN  = 1'b0,
    ACT_NARROW = 1'b1
  } action_e;

  localparam logic [15:0] HALF_SIGN = 16'h8000;
  localparam logic [15:0] HALF_INF  = 16'h7C00;
  localparam logic [31:0] SGL_INF   = 32'h7F80_0000;
  localparam logic [23:0] SGL_HID   = 24'h80_0000;
  localparam logic [23:0] RND_HALF  = 24'h00_1000;

endpackage

// ===== rtl/core/hsfc_convert.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// hsfc_convert
// Combinational binary16 <-> binary32 pattern conversion.
// ----------------------------------------------------------------------------
module hsfc_convert (
  input  logic [0:0]  action_i,
  input  logic [31:0] operand_i,
  output logic [31:0] converted_o
);

  logic [31:0] widen;
  logic [15:0] narrow;

  // half -> single
  always_comb begin
    logic [4:0] ex;
    logic [9:0] fr;
    logic [3:0] lz;
    logic [10:0] nf;
    ex = operand_i[14:10];
    fr = operand_i[9:0];
    lz = 4'd0;
    for (int i = 0; i < 10; i++) begin
      if (fr[i]) lz = 4'(9 - i);
    end
    nf = {1'b0, fr} << (lz + 4'd1);
    if (ex == 5'd0) begin
      if (fr == 10'd0) widen = {operand_i[15], 31'd0};
      else widen = {operand_i[15], 8'(8'd112 - {4'd0, lz}), nf[9:0], 13'd0};
    end else if (ex == 5'h1F) begin
      widen = {operand_i[15], 31'd0} | hsfc_pkg::SGL_INF | {9'd0, fr, 13'd0};
    end else begin
      widen = {operand_i[15], 8'({3'd0, ex} + 8'd112), fr, 13'd0};
    end
  end

  // single -> half, round half-up on magnitude
  always_comb begin
    logic [7:0]  e8;
    logic [23:0] m;
    logic [23:0] sh;
    logic [4:0]  amt;
    logic [11:0] r;
    logic [15:0] sgn;
    e8  = operand_i[30:23];
    sgn = operand_i[31] ? hsfc_pkg::HALF_SIGN : 16'd0;
    m   = {1'b0, operand_i[22:0]} | hsfc_pkg::SGL_HID;
    amt = 5'(8'd113 - e8);
    sh  = m >> amt;
    r   = 12'd0;
    if (e8 <= 8'd112) begin
      if (e8 < 8'd102) begin
        narrow = sgn;
      end else begin
        r = 12'((sh + hsfc_pkg::RND_HALF) >> 13);
        narrow = sgn | {4'd0, r};
      end
    end else if (e8 >= 8'd143) begin
      narrow = sgn | hsfc_pkg::HALF_INF;
    end else begin
      r = 12'(({1'b0, operand_i[22:0]} + hsfc_pkg::RND_HALF) >> 13);
      narrow = sgn | 16'({5'(e8 - 8'd112), 10'd0} + {4'd0, r});
    end
  end

  assign converted_o = (action_i == hsfc_pkg::ACT_NARROW) ? {16'd0, narrow} : widen;

endmodule

// ===== rtl/core/half_single_float_converter.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// half_single_float_converter
// Converts binary16 <-> binary32 bit patterns, one transfer per cycle while unstalled.
// ----------------------------------------------------------------------------
// Each input transfer is registered, converted by one short combinational
// stage, and placed in the result register: one item per cycle sustained
// while out_stall_i is low, set by the input and result register pair. A skid-free
// two-stage pipeline that advances whenever its downstream slot is free.
module half_single_float_converter (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [0:0]  action_i,
  input  logic [31:0] operand_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [31:0] converted_o
);

  logic        a_vld_q;
  logic [0:0]  act_q;
  logic [31:0] opd_q;
  logic        r_vld_q;
  logic [31:0] res_q;
  logic [31:0] res_d;
  logic        r_adv;
  logic        a_adv;

  hsfc_convert u_conv (
    .action_i   (act_q),
    .operand_i  (opd_q),
    .converted_o(res_d)
  );

  assign r_adv      = !r_vld_q || !out_stall_i;
  assign a_adv      = !a_vld_q || r_adv;
  assign in_stall_o = !a_adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      a_vld_q <= 1'b0;
      r_vld_q <= 1'b0;
    end else begin
      if (r_adv) r_vld_q <= a_vld_q;
      if (a_adv) a_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (r_adv && a_vld_q) res_q <= res_d;
    if (a_adv && in_valid_i) begin
      act_q <= action_i;
      opd_q <= operand_i;
    end
  end

  assign out_valid_o = r_vld_q;
  assign converted_o = res_q;

endmodule

// ===== tb/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the binary16/binary32 converter: drives directed
// corner patterns and random operands in both directions, predicts each
// converted pattern, and checks results in order under random idle and stall.
// ----------------------------------------------------------------------------
module testbench;

  class conv_scoreboard;
    logic [31:0] pending_q[$];
    int unsigned errors;
    int unsigned checked;
    int unsigned n_widen;
    int unsigned n_narrow;

    function logic [31:0] half_to_single(logic [15:0] h);
      logic [31:0] sgn;
      logic [4:0]  ex;
      logic [10:0] fr;
      logic [7:0]  e;
      sgn = {h[15], 31'd0};
      ex  = h[14:10];
      fr  = {1'b0, h[9:0]};
      if (ex == 5'd0) begin
        if (fr == 11'd0) return sgn;
        e = 8'd113;
        while (fr[10] == 1'b0) begin
          fr = fr << 1;
          e  = e - 8'd1;
        end
        return sgn | {1'b0, e, fr[9:0], 13'd0};
      end
      if (ex == 5'h1F) return sgn | 32'h7F80_0000 | {9'd0, fr[9:0], 13'd0};
      return sgn | {1'b0, 8'(ex + 8'd112), fr[9:0], 13'd0};
    endfunction

    function logic [31:0] single_to_half(logic [31:0] x);
      logic [15:0] sgn;
      int          ex;
      logic [31:0] fr;
      sgn = {x[31], 15'd0};
      ex  = int'(x[30:23]) - 112;
      fr  = {9'd0, x[22:0]};
      if (ex <= 0) begin
        if (ex < -10) return {16'd0, sgn};
        fr = (fr | 32'h0080_0000) >> (1 - ex);
        return {16'd0, sgn | 16'((fr + 32'h1000) >> 13)};
      end
      if (ex >= 31) return {16'd0, sgn | 16'h7C00};
      return {16'd0, sgn | 16'((ex << 10) + ((fr + 32'h1000) >> 13))};
    endfunction

    function void note_input(hsfc_pkg::action_e act, logic [31:0] op);
      if (act == hsfc_pkg::ACT_WIDEN) begin
        pending_q.push_back(half_to_single(op[15:0]));
        n_widen++;
      end else begin
        pending_q.push_back(single_to_half(op));
        n_narrow++;
      end
    endfunction

    function void check_result(logic [31:0] got);
      logic [31:0] exp_v;
      checked++;
      if (pending_q.size() == 0) begin
        errors++;
        $display("%0t: unexpected result %h", $time, got);
        return;
      end
      exp_v = pending_q.pop_front();
      if (got !== exp_v) begin
        errors++;
        $display("%0t: converted mismatch expected %h actual %h", $time, exp_v, got);
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        in_valid_i = 1'b0;
  logic        in_stall_o;
  logic [0:0]  action_i = '0;
  logic [31:0] operand_i = '0;
  logic        out_valid_o;
  logic        out_stall_i = 1'b1;
  logic [31:0] converted_o;

  conv_scoreboard sb = new();
  int unsigned send_idle_pct = 0;
  int unsigned recv_stall_pct = 0;
  bit          hold_off = 1'b0;

  always #2 clk_i = ~clk_i;

  half_single_float_converter u_top (.*);

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) sb.check_result(converted_o);
    if (hold_off) out_stall_i <= 1'b1;
    else out_stall_i <= ($urandom_range(99) < recv_stall_pct);
  end

  task automatic send_item(hsfc_pkg::action_e act, logic [31:0] op);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    action_i   <= act;
    operand_i  <= op;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    sb.note_input(act, op);
  endtask

  task automatic go_idle();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    go_idle();
    while (sb.pending_q.size() != 0) @(posedge clk_i);
  endtask

  function automatic logic [31:0] rand_single();
    logic [31:0] x;
    x = $urandom;
    case ($urandom_range(5))
      0: x[30:23] = 8'($urandom_range(101, 113));
      1: x[30:23] = 8'($urandom_range(140, 143));
      2: x[30:23] = $urandom_range(1) ? 8'hFF : 8'h00;
      3: x[22:0]  = {10'($urandom), 1'b0, 12'($urandom_range(1) ? 12'hFFF : 12'h000)};
      default: x[30:23] = 8'($urandom_range(95, 150));
    endcase
    return x;
  endfunction

  task automatic random_phase(int n);
    repeat (n) begin
      if ($urandom_range(1)) send_item(hsfc_pkg::ACT_WIDEN, $urandom);
      else send_item(hsfc_pkg::ACT_NARROW, rand_single());
    end
  endtask

  initial begin
    logic [31:0] dir_half[$];
    logic [31:0] dir_single[$];
    dir_half = {32'h0000, 32'h8000, 32'h0001, 32'h83FF, 32'h0400, 32'h7BFF,
                32'h7C00, 32'hFC00, 32'h7E01, 32'hFFFF_3C00};
    dir_single = {32'h0000_0000, 32'h8000_0001, 32'h3880_0000, 32'h3300_0000,
                  32'h3380_0000, 32'hB87F_F000, 32'h477F_F000, 32'h477F_EFFF,
                  32'h4780_0000, 32'h7F80_0000, 32'hFFC0_0001, 32'h3F80_1000,
                  32'h3F80_0FFF};
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    foreach (dir_half[i]) send_item(hsfc_pkg::ACT_WIDEN, dir_half[i]);
    foreach (dir_single[i]) send_item(hsfc_pkg::ACT_NARROW, dir_single[i]);
    send_idle_pct = 20;
    recv_stall_pct = 88;
    random_phase(330);
    send_idle_pct = 88;
    recv_stall_pct = 20;
    random_phase(330);
    drain();
    send_idle_pct = 0;
    recv_stall_pct = 0;
    hold_off = 1'b1;
    fork
      begin
        repeat (60) @(posedge clk_i);
        hold_off = 1'b0;
      end
      random_phase(40);
    join
    random_phase(320);
    drain();
    repeat (10) @(posedge clk_i);
    $display("Checked %0d results: %0d widen and %0d narrow items, corners and random.",
             sb.checked, sb.n_widen, sb.n_narrow);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

  initial begin
    #2000000;
    $display("TB_ERROR");
    $finish;
  end
endmodule
